FILE: design/nhds_pkg.sv
`timescale 1ns / 1ps
package nhds_pkg;

  // Default sizes of the token store and the draft buffer.
  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int TOKEN_BITS_DEF    = 16;
  localparam int DRAFT_SLOTS_DEF   = 8;

  // Longest n-gram that the comparator window covers.
  localparam int ORDER_MAX = 8;

  // Fixed widths of the stream fields.
  localparam int TOKEN_W = 16;
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 3;

  // Command codes carried on in_tuser.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_DRAFT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Register selects, taken from cfg_paddr[2].
  localparam logic REG_NGRAM_ORDER = 1'b0;
  localparam logic REG_MAX_DRAFT   = 1'b1;

  localparam logic [3:0] NGRAM_ORDER_RST = 4'd3;
  localparam logic [3:0] MAX_DRAFT_RST   = 4'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NEXT = 5'b00010,
    S_LOAD = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

FILE: design/ngram_history_draft_search.sv
// Append, clear and unused commands: one word, shown in the cycle after acceptance.
// Draft request: the trailing n-gram is fetched first, then each draft scans the
// sequence through the single read port, then one result word per cycle while
// the receiver takes them (out_tready high).
// A new word is taken once the previous item's last result has been taken.
// rst_n (synchronous) empties the history and restores the registers; the store is kept.
`timescale 1ns / 1ps
module ngram_history_draft_search
  import nhds_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int TOKEN_BITS    = TOKEN_BITS_DEF,
  parameter int DRAFT_SLOTS   = DRAFT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // token[15:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // draft_token[15:0], draft_index[18:16], history_count[31:19]
  output logic [1:0]  out_tuser,  // found[0], history_full[1]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = AW + 1;
  localparam int NW  = $clog2(DRAFT_SLOTS + 1);
  localparam int DIW = (DRAFT_SLOTS > 1) ? $clog2(DRAFT_SLOTS) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(HISTORY_DEPTH);

  state_t state_r;

  logic [3:0]    ngram_order_r, max_draft_r;
  logic [3:0]    order_r;
  logic [NW-1:0] limit_r, n_r, k_r;
  logic [CW-1:0] len_r, iss_r, cp_r;
  logic          rd_vld_r, hit_r;

  logic [TOKEN_BITS-1:0] mem [HISTORY_DEPTH];
  logic [TOKEN_BITS-1:0] mem_q_r, drf_q_r;
  logic                  sel_drf_r;
  logic [TOKEN_BITS-1:0] win_r [ORDER_MAX-1];
  logic [TOKEN_BITS-1:0] pat_r [ORDER_MAX];
  logic [TOKEN_BITS-1:0] drafts_r [DRAFT_SLOTS];

  logic                 out_tvalid_r, out_found_r, out_last_r, out_full_r;
  logic [TOKEN_W-1:0]   out_tok_r;
  logic [INDEX_W-1:0]   out_idx_r;
  logic [COUNT_W-1:0]   out_cnt_r;

  logic                  acc, out_free, ack, has_room;
  logic [3:0]            order_eff;
  logic [NW-1:0]         limit_eff;
  logic [CW-1:0]         total, diff;
  logic                  iss_en, consume, take_draft, scan_end, scan_step, hit_now;
  logic                  load_step, load_done, go_on, out_emit, emit_last, match;
  logic [TOKEN_BITS-1:0] rd_tok;
  logic [TOKEN_BITS-1:0] win_new [ORDER_MAX];

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_DRAFT) ? {28'd0, max_draft_r}
                                                       : {28'd0, ngram_order_r};

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = rst_n && (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign ack       = acc && (in_tuser != CMD_DRAFT);
  assign has_room  = len_r < DEPTH_C;

  always_comb begin
    if (ngram_order_r == 4'd0) begin
      order_eff = 4'd1;
    end else if (ngram_order_r > 4'(ORDER_MAX)) begin
      order_eff = 4'(ORDER_MAX);
    end else begin
      order_eff = ngram_order_r;
    end
    if (max_draft_r > 4'(DRAFT_SLOTS)) begin
      limit_eff = NW'(DRAFT_SLOTS);
    end else begin
      limit_eff = NW'(max_draft_r);
    end
  end

  assign total = len_r + CW'(n_r);
  assign diff  = iss_r - len_r;

  // One read a cycle: pattern fetch in LOAD, the running scan in SCAN.
  assign iss_en = ((state_r == S_LOAD) && (iss_r < len_r)) ||
                  ((state_r == S_SCAN) && !hit_r && (iss_r < total));

  assign rd_tok = sel_drf_r ? drf_q_r : mem_q_r;

  always_comb begin
    win_new[0] = rd_tok;
    for (int k = 1; k < ORDER_MAX; k++) begin
      win_new[k] = win_r[k-1];
    end
    match = (cp_r + CW'(1)) >= CW'(order_r);
    for (int k = 0; k < ORDER_MAX; k++) begin
      if ((4'(k) < order_r) && (win_new[k] != pat_r[k])) begin
        match = 1'b0;
      end
    end
  end

  // The window matches at the word before the candidate draft, so the draft word is
  // already in flight when the match is seen.
  assign consume    = (state_r == S_SCAN) && rd_vld_r;
  assign take_draft = consume && hit_r;
  assign scan_end   = consume && !hit_r && (cp_r == total - CW'(1));
  assign scan_step  = consume && !hit_r && (cp_r != total - CW'(1));
  assign hit_now    = scan_step && match;
  assign load_step  = (state_r == S_LOAD) && rd_vld_r;
  assign load_done  = load_step && (cp_r == len_r - CW'(1));
  assign go_on      = (n_r < limit_r) && (len_r >= CW'(order_r)) &&
                      (((CW+1)'(total) + (CW+1)'(1)) < DEPTH_X);
  assign out_emit   = (state_r == S_OUT) && out_free;
  assign emit_last  = (n_r == '0) || (k_r == n_r - NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ngram_order_r <= NGRAM_ORDER_RST;
      max_draft_r   <= MAX_DRAFT_RST;
      order_r       <= 4'd1;
      limit_r       <= '0;
      n_r           <= '0;
      k_r           <= '0;
      len_r         <= '0;
      iss_r         <= '0;
      rd_vld_r      <= 1'b0;
      hit_r         <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_MAX_DRAFT) begin
          max_draft_r <= cfg_pwdata[3:0];
        end else begin
          ngram_order_r <= cfg_pwdata[3:0];
        end
      end

      rd_vld_r <= iss_en;
      if (iss_en) begin
        iss_r <= iss_r + CW'(1);
      end

      if (ack || out_emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            priority if (in_tuser == CMD_APPEND) begin
              if (has_room) begin
                len_r <= len_r + CW'(1);
              end
            end else if (in_tuser == CMD_CLEAR) begin
              len_r <= '0;
            end else if (in_tuser == CMD_DRAFT) begin
              order_r <= order_eff;
              limit_r <= limit_eff;
              n_r     <= '0;
              k_r     <= '0;
              state_r <= S_NEXT;
            end else begin
              len_r <= len_r;
            end
          end
        end
        S_NEXT: begin
          hit_r <= 1'b0;
          if (!go_on) begin
            state_r <= S_OUT;
          end else if (n_r == '0) begin
            iss_r   <= len_r - CW'(order_r);
            state_r <= S_LOAD;
          end else begin
            iss_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_LOAD: begin
          if (load_done) begin
            iss_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take_draft) begin
            n_r     <= n_r + NW'(1);
            hit_r   <= 1'b0;
            state_r <= S_NEXT;
          end else if (scan_end) begin
            state_r <= S_OUT;
          end else if (hit_now) begin
            hit_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_emit) begin
            k_r <= k_r + NW'(1);
            if (emit_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Token store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (acc && (in_tuser == CMD_APPEND) && has_room) begin
      mem[len_r[AW-1:0]] <= TOKEN_BITS'(in_tdata);
    end
    if (iss_en) begin
      mem_q_r <= mem[iss_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (iss_en) begin
      drf_q_r   <= drafts_r[diff[DIW-1:0]];
      sel_drf_r <= iss_r >= len_r;
      cp_r      <= iss_r;
    end
    if (scan_step) begin
      for (int k = 0; k < ORDER_MAX - 1; k++) begin
        win_r[k] <= win_new[k];
      end
    end
    if (load_step || take_draft) begin
      pat_r[0] <= rd_tok;
      for (int k = 1; k < ORDER_MAX; k++) begin
        pat_r[k] <= pat_r[k-1];
      end
    end
    if (take_draft) begin
      drafts_r[n_r[DIW-1:0]] <= rd_tok;
    end

    if (ack) begin
      out_tok_r   <= '0;
      out_found_r <= 1'b0;
      out_idx_r   <= '0;
      out_last_r  <= 1'b1;
      out_full_r  <= (in_tuser == CMD_APPEND) && !has_room;
      priority if (in_tuser == CMD_CLEAR) begin
        out_cnt_r <= '0;
      end else if ((in_tuser == CMD_APPEND) && has_room) begin
        out_cnt_r <= COUNT_W'(len_r + CW'(1));
      end else begin
        out_cnt_r <= COUNT_W'(len_r);
      end
    end else if (out_emit) begin
      out_found_r <= n_r != '0;
      out_tok_r   <= (n_r != '0) ? TOKEN_W'(drafts_r[k_r[DIW-1:0]]) : '0;
      out_idx_r   <= INDEX_W'(k_r);
      out_last_r  <= emit_last;
      out_full_r  <= 1'b0;
      out_cnt_r   <= COUNT_W'(len_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_cnt_r, out_idx_r, out_tok_r};
  assign out_tuser  = {out_full_r, out_found_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: design/nhds_checker.sv
`timescale 1ns / 1ps
module nhds_checker
  import nhds_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Append, clear and unused commands answer with a single word in the next cycle.
  a_ack_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != CMD_DRAFT)) |=> (out_tvalid && out_tlast))
    else $error("acknowledgement word missing after a non-draft command");

  // A clear leaves an empty history in its acknowledgement.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_CLEAR)) |=> (out_tdata[31:19] == '0))
    else $error("clear acknowledged with a non-zero history count");

  // A word without a proposal always closes its item.
  a_nofind_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("word without a draft is not the last of its item");

  // Drafts never report a dropped token.
  a_draft_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tuser[1])
    else $error("draft word flags a full history");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output word changed");

endmodule

bind ngram_history_draft_search nhds_checker u_nhds_checker (.*);

FILE: bench/ngram_history_draft_search_test.sv
`timescale 1ns / 1ps
module ngram_history_draft_search_test;
  import nhds_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] tok;
  } cmd_word_t;

  typedef struct packed {
    logic [15:0] draft_token;
    logic        found;
    logic [2:0]  draft_index;
    logic        last;
    logic        history_full;
    logic [12:0] history_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_APPEND;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Words waiting to be offered, and replies still owed by the block.
  cmd_word_t cmd_q[$];
  reply_t    reply_q[$];

  // Our own copy of the history and of the two registers.
  logic [15:0] hist_mem [0:HISTORY_DEPTH_DEF-1];
  int          hist_len = 0;
  logic [15:0] draft_buf [0:7];
  logic [3:0]  ngram_order_r = NGRAM_ORDER_RST;
  logic [3:0]  max_draft_r = MAX_DRAFT_RST;

  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  logic      in_took = 1'b0;
  int        gap_max = 0;
  int        stall_pct = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  int        hold_left = 0;
  bit        hold_req = 1'b0;
  cmd_word_t next_word;

  ngram_history_draft_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // token[15:0]
    .in_tuser   (in_tuser),     // command[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // draft_token[15:0], draft_index[18:16], history_count[31:19]
    .out_tuser  (out_tuser),    // found[0], history_full[1]
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] seq_tok(input int p);
    if (p < hist_len) return hist_mem[p];
    return draft_buf[(p - hist_len) & 7];
  endfunction

  function automatic void push_reply(input logic [15:0] tok, input logic found,
                                     input logic [2:0] idx, input logic last,
                                     input logic full);
    reply_t r;
    r.draft_token   = tok;
    r.found         = found;
    r.draft_index   = idx;
    r.last          = last;
    r.history_full  = full;
    r.history_count = hist_len[12:0];
    reply_q.push_back(r);
  endfunction

  task automatic run_command(input logic [1:0] cmd, input logic [15:0] tok);
    int order;
    int limit;
    int n;
    int total;
    int tail;
    int i;
    int j;
    bit hit;
    bit same;
    case (cmd)
      CMD_APPEND: begin
        if (hist_len < HISTORY_DEPTH_DEF) begin
          hist_mem[hist_len] = tok;
          hist_len++;
          push_reply('0, 1'b0, '0, 1'b1, 1'b0);
        end else begin
          push_reply('0, 1'b0, '0, 1'b1, 1'b1);
        end
      end
      CMD_CLEAR: begin
        hist_len = 0;
        push_reply('0, 1'b0, '0, 1'b1, 1'b0);
      end
      CMD_DRAFT: begin
        order = (ngram_order_r == 0) ? 1 :
                (ngram_order_r > ORDER_MAX) ? ORDER_MAX : int'(ngram_order_r);
        limit = (max_draft_r > DRAFT_SLOTS_DEF) ? DRAFT_SLOTS_DEF : int'(max_draft_r);
        n = 0;
        if (hist_len >= order) begin
          hit = 1'b1;
          // Each draft extends the sequence that the next search runs over.
          while (hit && n < limit && hist_len + n + 1 < HISTORY_DEPTH_DEF) begin
            total = hist_len + n;
            tail  = total - order;
            hit   = 1'b0;
            for (i = 0; i < tail && !hit; i++) begin
              same = 1'b1;
              for (j = 0; j < order && same; j++)
                if (seq_tok(i + j) !== seq_tok(tail + j)) same = 1'b0;
              if (same) begin
                draft_buf[n] = seq_tok(i + order);
                hit = 1'b1;
              end
            end
            if (hit) n++;
          end
        end
        if (n == 0) begin
          push_reply('0, 1'b0, '0, 1'b1, 1'b0);
        end else begin
          for (i = 0; i < n; i++)
            push_reply(draft_buf[i], 1'b1, i[2:0], (i == n - 1), 1'b0);
        end
      end
      default: begin
        push_reply('0, 1'b0, '0, 1'b1, 1'b0);
      end
    endcase
  endtask

  function automatic void match_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic compare_reply();
    reply_t r;
    if (reply_q.size() == 0) begin
      $error("result word with nothing outstanding: tdata %h tuser %b tlast %b",
             out_tdata, out_tuser, out_tlast);
      fail_cnt++;
    end else begin
      r = reply_q.pop_front();
      match_field("draft_token", r.draft_token, out_tdata[15:0]);
      match_field("found", 16'(r.found), 16'(out_tuser[0]));
      match_field("draft_index", 16'(r.draft_index), 16'(out_tdata[18:16]));
      match_field("last", 16'(r.last), 16'(out_tlast));
      match_field("history_full", 16'(r.history_full), 16'(out_tuser[1]));
      match_field("history_count", 16'(r.history_count), 16'(out_tdata[31:19]));
    end
  endtask

  // Sampling side: predictions at input acceptance, checks at output acceptance.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL ngram_history_draft_search");
      $finish;
    end else begin
      in_took <= rst_n && in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready) run_command(in_tuser, in_tdata);
      if (rst_n && out_tvalid && out_tready) compare_reply();
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        next_word = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_word.tok;
        in_tuser  <= next_word.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off in a phase that asks for it.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [15:0] tok);
    cmd_word_t w;
    w.cmd = cmd;
    w.tok = tok;
    cmd_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_tvalid || reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [3:0] value);
    logic [31:0] wdata;
    wdata = $urandom;
    wdata[3:0] = value;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_sel == REG_NGRAM_ORDER) ngram_order_r = value;
    else max_draft_r = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly appends from a small alphabet so that n-grams repeat, with drafts
  // spread among them and the odd clear, stray token or unused command.
  task automatic plan_words(input int n_items);
    logic [15:0] alpha [4];
    int          n_alpha;
    int          planned_len;
    int          k;
    int          pick;
    n_alpha = $urandom_range(2, 4);
    for (k = 0; k < 4; k++) alpha[k] = 16'($urandom);
    planned_len = 0;
    queue_word(CMD_CLEAR, 16'($urandom));
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (planned_len > 48) begin
        queue_word(CMD_CLEAR, 16'($urandom));
        planned_len = 0;
      end else if (pick < 55) begin
        queue_word(CMD_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
        planned_len++;
      end else if (pick < 60) begin
        queue_word(CMD_APPEND, 16'($urandom));
        planned_len++;
      end else if (pick < 88) begin
        queue_word(CMD_DRAFT, 16'($urandom));
      end else if (pick < 95) begin
        queue_word(CMD_CLEAR, 16'($urandom));
        planned_len = 0;
      end else begin
        queue_word(CMD_UNUSED, 16'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [3:0] order, input logic [3:0] drafts,
                           input int gaps, input int stall, input int n_items,
                           input bit long_hold);
    wait_idle();
    cfg_write(REG_NGRAM_ORDER, order);
    cfg_write(REG_MAX_DRAFT, drafts);
    gap_max   = gaps;
    stall_pct = stall;
    @(posedge clk);
    if (long_hold) hold_req = 1'b1;
    plan_words(n_items);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty and short history, a run of full length, no match.
    gap_max   = 2;
    stall_pct = 20;
    queue_word(CMD_DRAFT, 16'hFFFF);
    queue_word(CMD_APPEND, 16'hFFFF);
    queue_word(CMD_DRAFT, 16'h0000);
    queue_word(CMD_APPEND, 16'h0000);
    queue_word(CMD_APPEND, 16'h8001);
    queue_word(CMD_APPEND, 16'h7FFE);
    queue_word(CMD_APPEND, 16'hFFFF);
    queue_word(CMD_APPEND, 16'h0000);
    queue_word(CMD_APPEND, 16'h8001);
    queue_word(CMD_DRAFT, 16'h5A5A);
    queue_word(CMD_UNUSED, 16'hA5A5);
    queue_word(CMD_APPEND, 16'h1234);
    queue_word(CMD_DRAFT, 16'h0000);
    queue_word(CMD_CLEAR, 16'hFFFF);
    queue_word(CMD_DRAFT, 16'h0000);

    run_phase(4'd1,  4'd8,  3, 30, 18, 1'b1);
    run_phase(4'd8,  4'd8,  0,  0, 18, 1'b0);
    run_phase(4'd2,  4'd1,  5, 60, 16, 1'b0);
    run_phase(4'd0,  4'd3,  2, 20, 16, 1'b0);
    run_phase(4'd15, 4'd15, 0, 40, 18, 1'b0);
    run_phase(4'd4,  4'd0,  3, 10, 12, 1'b0);
    run_phase(4'd9,  4'd6,  1, 50, 16, 1'b0);
    run_phase(4'd3,  4'd4,  4, 25, 18, 1'b0);

    wait_idle();
    repeat (50) @(posedge clk);
    if (reply_q.size() != 0) begin
      $error("%0d expected result words never arrived", reply_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("PASS ngram_history_draft_search");
    end else begin
      $display("FAIL ngram_history_draft_search");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/nhds_pkg.sv
design/ngram_history_draft_search.sv
design/nhds_checker.sv
bench/ngram_history_draft_search_test.sv
